// ----- rtl/losbt_pkg.sv -----
// widths, stage payload types and item codes shared by the line-of-sight box test
`timescale 1ns / 1ps

package losbt_pkg;

  localparam int CoordW   = 24;
  localparam int RangeW   = 23;
  localparam int DiffW    = CoordW + 1;
  localparam int PosW     = CoordW + 2;
  localparam int SqW      = 2 * DiffW;
  localparam int RangeSqW = 2 * RangeW;
  localparam int DistW    = SqW + 1;
  localparam int ProdW    = PosW + DiffW + 1;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic                     is_player;
    logic                     last;
    logic [RangeW-1:0]        sight_range;
    logic signed [CoordW-1:0] wid;
    logic signed [CoordW-1:0] hgt;
    logic signed [DiffW-1:0]  sq_x;
    logic signed [DiffW-1:0]  sq_y;
    logic signed [DiffW-1:0]  rx;
    logic signed [DiffW-1:0]  ry;
    logic signed [DiffW-1:0]  pxa;
    logic signed [DiffW-1:0]  pya;
    logic signed [PosW-1:0]   pxb;
    logic signed [PosW-1:0]   pyb;
  } diff_t;

  typedef struct packed {
    logic                    kind;
    logic                    is_player;
    logic                    last;
    logic [SqW-1:0]          sq_x;
    logic [SqW-1:0]          sq_y;
    logic [RangeSqW-1:0]     range_sq;
    logic signed [ProdW-1:0] dh;
    logic signed [ProdW-1:0] dv;
    logic signed [ProdW-1:0] t1;
    logic signed [ProdW-1:0] t2;
    logic signed [ProdW-1:0] t3;
    logic signed [ProdW-1:0] t4;
    logic signed [ProdW-1:0] pxa_ry;
    logic signed [ProdW-1:0] pxb_ry;
    logic signed [ProdW-1:0] pya_rx;
    logic signed [ProdW-1:0] pyb_rx;
  } prod_t;

  typedef struct packed {
    logic load;
    logic retire;
    logic emit;
  } eval_ctl_t;

endpackage

// ----- rtl/losbt_front.sv -----
// input register, origin and target state, and the coordinate differences
`timescale 1ns / 1ps

module losbt_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  kind,
  input  logic signed [losbt_pkg::CoordW-1:0]   first_x,
  input  logic signed [losbt_pkg::CoordW-1:0]   first_y,
  input  logic signed [losbt_pkg::CoordW-1:0]   second_x,
  input  logic signed [losbt_pkg::CoordW-1:0]   second_y,
  input  logic [losbt_pkg::RangeW-1:0]          sight_range,
  input  logic                                  is_player,
  input  logic                                  last,
  output losbt_pkg::diff_t                      diff
);
  import losbt_pkg::*;

  logic                     s1_kind;
  logic signed [CoordW-1:0] s1_a;
  logic signed [CoordW-1:0] s1_b;
  logic signed [CoordW-1:0] s1_c;
  logic signed [CoordW-1:0] s1_e;
  logic [RangeW-1:0]        s1_range;
  logic                     s1_player;
  logic                     s1_last;

  logic signed [CoordW-1:0] origin_x;
  logic signed [CoordW-1:0] origin_y;
  logic signed [CoordW-1:0] target_x;
  logic signed [CoordW-1:0] target_y;

  logic signed [DiffW-1:0]  qdx;
  logic signed [DiffW-1:0]  qdy;
  logic signed [DiffW-1:0]  pxa;
  logic signed [DiffW-1:0]  pya;

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind   <= kind;
      s1_a      <= first_x;
      s1_b      <= first_y;
      s1_c      <= second_x;
      s1_e      <= second_y;
      s1_range  <= sight_range;
      s1_player <= is_player;
      s1_last   <= last;
    end
  end

  // the query's endpoints are taken at transfer, so the object right behind it sees them
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      target_x <= '0;
      target_y <= '0;
    end else if (load && kind == KIND_QUERY) begin
      origin_x <= first_x;
      origin_y <= first_y;
      target_x <= second_x;
      target_y <= second_y;
    end
  end

  always_comb begin
    qdx = DiffW'(s1_c) - DiffW'(s1_a);
    qdy = DiffW'(s1_e) - DiffW'(s1_b);
    pxa = DiffW'(s1_a) - DiffW'(origin_x);
    pya = DiffW'(s1_b) - DiffW'(origin_y);

    diff.kind        = s1_kind;
    diff.is_player   = s1_player;
    diff.last        = s1_last;
    diff.sight_range = s1_range;
    diff.wid         = s1_c;
    diff.hgt         = s1_e;
    diff.rx          = DiffW'(target_x) - DiffW'(origin_x);
    diff.ry          = DiffW'(target_y) - DiffW'(origin_y);
    diff.pxa         = pxa;
    diff.pya         = pya;
    diff.pxb         = PosW'(s1_a) + PosW'(s1_c) - PosW'(origin_x);
    diff.pyb         = PosW'(s1_b) + PosW'(s1_e) - PosW'(origin_y);
    // one pair of squarers serves the target distance and the corner distance
    diff.sq_x        = (s1_kind == KIND_OBJECT) ? pxa : qdx;
    diff.sq_y        = (s1_kind == KIND_OBJECT) ? pya : qdy;
  end

endmodule

// ----- rtl/losbt_mult.sv -----
// difference register and the bank of squares and cross-product terms
`timescale 1ns / 1ps

module losbt_mult (
  input  logic              clk,
  input  logic              load,
  input  losbt_pkg::diff_t  diff_in,
  output losbt_pkg::prod_t  prod
);
  import losbt_pkg::*;

  diff_t d2;

  logic signed [DiffW-1:0]       rx;
  logic signed [DiffW-1:0]       ry;
  logic signed [DiffW-1:0]       pxa;
  logic signed [DiffW-1:0]       pya;
  logic signed [DiffW-1:0]       sqx;
  logic signed [DiffW-1:0]       sqy;
  logic signed [PosW-1:0]        pxb;
  logic signed [PosW-1:0]        pyb;
  logic signed [CoordW-1:0]      wid;
  logic signed [CoordW-1:0]      hgt;

  logic signed [DiffW+CoordW-1:0] dh_p;
  logic signed [DiffW+CoordW-1:0] dv_p;
  logic signed [DiffW+CoordW-1:0] t1_p;
  logic signed [DiffW+CoordW-1:0] t4_p;
  logic signed [PosW+CoordW-1:0]  t2_p;
  logic signed [PosW+CoordW-1:0]  t3_p;
  logic signed [SqW-1:0]          sqx_p;
  logic signed [SqW-1:0]          sqy_p;
  logic signed [SqW-1:0]          pxa_ry_p;
  logic signed [SqW-1:0]          pya_rx_p;
  logic signed [PosW+DiffW-1:0]   pxb_ry_p;
  logic signed [PosW+DiffW-1:0]   pyb_rx_p;
  logic [RangeSqW-1:0]            range_sq_p;

  always_ff @(posedge clk) begin
    if (load) begin
      d2 <= diff_in;
    end
  end

  always_comb begin
    rx  = d2.rx;
    ry  = d2.ry;
    pxa = d2.pxa;
    pya = d2.pya;
    pxb = d2.pxb;
    pyb = d2.pyb;
    sqx = d2.sq_x;
    sqy = d2.sq_y;
    wid = d2.wid;
    hgt = d2.hgt;

    // edge denominators and t numerators, signs folded so no negation is needed
    dh_p       = ry * wid;
    dv_p       = rx * hgt;
    t1_p       = pya * wid;
    t2_p       = pxb * hgt;
    t3_p       = pyb * wid;
    t4_p       = pxa * hgt;
    pxa_ry_p   = pxa * ry;
    pya_rx_p   = pya * rx;
    pxb_ry_p   = pxb * ry;
    pyb_rx_p   = pyb * rx;
    sqx_p      = sqx * sqx;
    sqy_p      = sqy * sqy;
    range_sq_p = d2.sight_range * d2.sight_range;

    prod.kind      = d2.kind;
    prod.is_player = d2.is_player;
    prod.last      = d2.last;
    prod.sq_x      = $unsigned(sqx_p);
    prod.sq_y      = $unsigned(sqy_p);
    prod.range_sq  = range_sq_p;
    prod.dh        = ProdW'(dh_p);
    prod.dv        = ProdW'(dv_p);
    prod.t1        = ProdW'(t1_p);
    prod.t2        = ProdW'(t2_p);
    prod.t3        = ProdW'(t3_p);
    prod.t4        = ProdW'(t4_p);
    prod.pxa_ry    = ProdW'(pxa_ry_p);
    prod.pxb_ry    = ProdW'(pxb_ry_p);
    prod.pya_rx    = ProdW'(pya_rx_p);
    prod.pyb_rx    = ProdW'(pyb_rx_p);
  end

endmodule

// ----- rtl/losbt_eval.sv -----
// product register, edge tests, range and blocked state, and the result register
`timescale 1ns / 1ps

module losbt_eval (
  input  logic                 clk,
  input  logic                 rst,
  input  losbt_pkg::eval_ctl_t ctl,
  input  losbt_pkg::prod_t     prod_in,
  output logic                 last3,
  output logic                 visible
);
  import losbt_pkg::*;

  prod_t p3;

  logic [DistW-1:0]        target_dist_sq;
  logic                    in_range;
  logic                    blocked;

  logic [DistW-1:0]        target_dist_sq_next;
  logic                    in_range_next;
  logic                    blocked_next;

  logic [DistW-1:0]        dist_sum;
  logic                    range_ok;
  logic signed [ProdW-1:0] u1;
  logic signed [ProdW-1:0] u2;
  logic signed [ProdW-1:0] u3;
  logic signed [ProdW-1:0] u4;
  logic [3:0]              hit;
  logic                    skip;

  // num / den within [0,1]; den is known nonzero
  function automatic logic unit_ratio(input logic signed [ProdW-1:0] num,
                                      input logic signed [ProdW-1:0] den);
    logic ok;
    if (den > 0) begin
      ok = (num >= 0) && (num <= den);
    end else begin
      ok = (num <= 0) && (num >= den);
    end
    return ok;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p3 <= prod_in;
    end
  end

  always_comb begin
    dist_sum = DistW'(p3.sq_x) + DistW'(p3.sq_y);
    range_ok = dist_sum <= DistW'(p3.range_sq);

    u1 = p3.pya_rx - p3.pxa_ry;
    u2 = p3.pxb_ry - p3.pya_rx;
    u3 = p3.pxb_ry - p3.pyb_rx;
    u4 = p3.pyb_rx - p3.pxa_ry;

    // parallel or collinear edges give a zero denominator and never hit
    hit[0] = (p3.dh != '0) && unit_ratio(p3.t1, p3.dh) && unit_ratio(u1, p3.dh);
    hit[1] = (p3.dv != '0) && unit_ratio(p3.t2, p3.dv) && unit_ratio(u2, p3.dv);
    hit[2] = (p3.dh != '0) && unit_ratio(p3.t3, p3.dh) && unit_ratio(u3, p3.dh);
    hit[3] = (p3.dv != '0) && unit_ratio(p3.t4, p3.dv) && unit_ratio(u4, p3.dv);

    skip = p3.is_player || (dist_sum == '0) || (dist_sum > target_dist_sq);

    unique case (p3.kind)
      KIND_QUERY: begin
        target_dist_sq_next = dist_sum;
        in_range_next       = range_ok;
        blocked_next        = 1'b0;
      end
      KIND_OBJECT: begin
        target_dist_sq_next = target_dist_sq;
        in_range_next       = in_range;
        blocked_next        = blocked || (!skip && (hit != '0));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_dist_sq <= '0;
      in_range       <= 1'b0;
      blocked        <= 1'b0;
    end else if (ctl.retire) begin
      target_dist_sq <= target_dist_sq_next;
      in_range       <= in_range_next;
      blocked        <= blocked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      visible <= in_range_next && !blocked_next;
    end
  end

  assign last3 = p3.last;

endmodule

// ----- rtl/line_of_sight_box_test_top.sv -----
// Line-of-sight box test: a query item sets origin, target and sight range, each
// following object item tests the origin-target segment against one box, and the
// item marked last returns visible. One item is taken per clock while in_stall is low; an
// item passes the input register, the difference register and the product register, and
// its result is registered into visible, with the multipliers between the difference and
// product registers. Empty stages fill while a result waits at the output, so input stall
// rises only once all three stages are full, a last item sits in the final one and the output is held.
`timescale 1ns / 1ps

module line_of_sight_box_test_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [losbt_pkg::CoordW-1:0]  first_x,
  input  logic signed [losbt_pkg::CoordW-1:0]  first_y,
  input  logic signed [losbt_pkg::CoordW-1:0]  second_x,
  input  logic signed [losbt_pkg::CoordW-1:0]  second_y,
  input  logic [losbt_pkg::RangeW-1:0]         sight_range,
  input  logic                                 is_player,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 visible
);
  import losbt_pkg::*;

  diff_t     diff;
  prod_t     prod;
  eval_ctl_t ectl;

  logic v1;
  logic v2;
  logic v3;
  logic v1_next;
  logic v2_next;
  logic v3_next;
  logic out_valid_next;

  logic last3;
  logic accept;
  logic adv1;
  logic adv2;
  logic adv3;
  logic s2_free;
  logic s3_free;

  // items without last retire from the final stage without touching the output
  always_comb begin
    adv3      = v3 && (!last3 || !out_valid || !out_stall);
    s3_free   = !v3 || adv3;
    adv2      = v2 && s3_free;
    s2_free   = !v2 || adv2;
    adv1      = v1 && s2_free;
    in_stall  = v1 && !adv1;
    accept    = in_valid && !in_stall;

    v1_next        = accept || (v1 && !adv1);
    v2_next        = adv1 || (v2 && !adv2);
    v3_next        = adv2 || (v3 && !adv3);
    out_valid_next = (adv3 && last3) || (out_valid && out_stall);

    ectl.load   = adv2;
    ectl.retire = adv3;
    ectl.emit   = adv3 && last3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= v1_next;
      v2        <= v2_next;
      v3        <= v3_next;
      out_valid <= out_valid_next;
    end
  end

  losbt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .kind        (kind),
    .first_x     (first_x),
    .first_y     (first_y),
    .second_x    (second_x),
    .second_y    (second_y),
    .sight_range (sight_range),
    .is_player   (is_player),
    .last        (last),
    .diff        (diff)
  );

  losbt_mult u_mult (
    .clk     (clk),
    .load    (adv1),
    .diff_in (diff),
    .prod    (prod)
  );

  losbt_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ectl),
    .prod_in (prod),
    .last3   (last3),
    .visible (visible)
  );

`ifndef SYNTHESIS
  // input stall only when every stage is full behind a held result
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v2 && v3 && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // a new result only comes from a last item leaving the final stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && !$past(rst)) |-> $past(v3 && last3))
    else $error("result raised without a last item");

  // a transfer always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted item lost from the input register");
`endif

endmodule

// ----- tb/line_of_sight_box_test_top_test.sv -----
// testbench for the line-of-sight box test: queued stimulus, clocked driver and monitor
`timescale 1ns / 1ps

module line_of_sight_box_test_top_test;
  import losbt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int MAX_COORD = 8388607;
  localparam int MIN_COORD = -8388608;

  typedef struct {
    logic                     kind;
    logic signed [CoordW-1:0] fx;
    logic signed [CoordW-1:0] fy;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic [RangeW-1:0]        rng;
    logic                     player;
    logic                     lst;
    logic                     drain;
  } los_item_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_QUERY;
  logic signed [CoordW-1:0] first_x = '0;
  logic signed [CoordW-1:0] first_y = '0;
  logic signed [CoordW-1:0] second_x = '0;
  logic signed [CoordW-1:0] second_y = '0;
  logic [RangeW-1:0]        sight_range = '0;
  logic                     is_player = 1'b0;
  logic                     last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     visible;

  los_item_t item_q[$];
  bit        visible_due[$];
  bit        in_taken = 1'b0;
  int        taken_n = 0;
  int        total_items = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        gap_cnt = 0;
  int        stall_cnt = 0;
  logic [31:0] cyc = '0;

  // predictor state
  longint org_x = 0;
  longint org_y = 0;
  longint aim_x = 0;
  longint aim_y = 0;
  longint aim_dist_sq = 0;
  bit     in_reach = 1'b0;
  bit     view_blocked = 1'b0;

  line_of_sight_box_test_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .first_x     (first_x),
    .first_y     (first_y),
    .second_x    (second_x),
    .second_y    (second_y),
    .sight_range (sight_range),
    .is_player   (is_player),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .visible     (visible)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // num / den within [0,1], den nonzero
  function automatic bit ratio_in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic bit edge_crossed(longint qx, longint qy, longint sx, longint sy);
    longint rx, ry, px, py, d;
    rx = aim_x - org_x;
    ry = aim_y - org_y;
    px = qx - org_x;
    py = qy - org_y;
    d = rx * sy - ry * sx;
    if (d == 0) return 1'b0;
    return ratio_in_unit(px * sy - py * sx, d) && ratio_in_unit(px * ry - py * rx, d);
  endfunction

  task automatic predict_item();
    longint a, b, c, e, rng, d, x1, y1;
    a = longint'(first_x);
    b = longint'(first_y);
    c = longint'(second_x);
    e = longint'(second_y);
    rng = longint'(sight_range);
    if (kind == KIND_QUERY) begin
      org_x = a;
      org_y = b;
      aim_x = c;
      aim_y = e;
      aim_dist_sq = (c - a) * (c - a) + (e - b) * (e - b);
      in_reach = aim_dist_sq <= rng * rng;
      view_blocked = 1'b0;
    end else if (!is_player) begin
      d = (a - org_x) * (a - org_x) + (b - org_y) * (b - org_y);
      if (d != 0 && d <= aim_dist_sq) begin
        x1 = a + c;
        y1 = b + e;
        if (edge_crossed(a, b, c, 0) || edge_crossed(x1, b, 0, e) ||
            edge_crossed(x1, y1, -c, 0) || edge_crossed(a, y1, 0, -e)) begin
          view_blocked = 1'b1;
        end
      end
    end
    if (last) visible_due.push_back(in_reach && !view_blocked);
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_visible();
    bit want;
    if (visible_due.size() == 0) begin
      report_mismatch($sformatf("visible=%0b transfer with no result due", visible));
    end else begin
      want = visible_due.pop_front();
      if (visible !== want) report_mismatch($sformatf("visible=%0b, want %0b", visible, want));
    end
  endtask

  // mostly no pause, else short pauses and a few long ones, none at all in calm stretches
  function automatic int pick_pause(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic int span(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  task automatic add_query(int ox, int oy, int tx, int ty, int rng, bit lst, bit drain);
    los_item_t it;
    it.kind = KIND_QUERY;
    it.fx = CoordW'(ox);
    it.fy = CoordW'(oy);
    it.sx = CoordW'(tx);
    it.sy = CoordW'(ty);
    it.rng = RangeW'(rng);
    it.player = 1'($urandom_range(0, 1));
    it.lst = lst;
    it.drain = drain;
    item_q.push_back(it);
  endtask

  task automatic add_box(int x, int y, int w, int h, bit player, bit lst);
    los_item_t it;
    it.kind = KIND_OBJECT;
    it.fx = CoordW'(x);
    it.fy = CoordW'(y);
    it.sx = CoordW'(w);
    it.sy = CoordW'(h);
    it.rng = RangeW'($urandom_range(0, MAX_COORD));
    it.player = player;
    it.lst = lst;
    it.drain = 1'b0;
    item_q.push_back(it);
  endtask

  // sender side
  always @(negedge clk) begin : feed
    los_item_t cur;
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_cnt != 0) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (item_q.size() != 0 && !(item_q[0].drain && visible_due.size() != 0)) begin
        cur = item_q.pop_front();
        in_valid <= 1'b1;
        kind <= cur.kind;
        first_x <= cur.fx;
        first_y <= cur.fy;
        second_x <= cur.sx;
        second_y <= cur.sy;
        sight_range <= cur.rng;
        is_player <= cur.player;
        last <= cur.lst;
        gap_cnt <= pick_pause(cyc[8:7] == 2'b00);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver side
  always @(negedge clk) begin : back_pressure
    int n;
    if (stall_cnt != 0) begin
      out_stall <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end else begin
      n = pick_pause(cyc[9:8] == 2'b01);
      out_stall <= n != 0;
      stall_cnt <= (n != 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) check_visible();
      if (in_valid && !in_stall) begin
        taken_n <= taken_n + 1;
        predict_item();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("line_of_sight_box_test_top_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int sc, ox, oy, tx, ty, rng, nobj, q_no, sz, w, h, bx, by, f;
    longint px, py;

    // object before any query uses the reset state
    add_box(0, 0, 2560, 2560, 1'b0, 1'b1);
    // player box on the line is ignored
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(12800, -1280, 2560, 2560, 1'b1, 1'b1);
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(12800, -1280, 2560, 2560, 1'b0, 1'b1);
    // corner beyond the target is skipped even though the box spans the line
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(30000, -1280, -5120, 2560, 1'b0, 1'b1);
    // corner on the origin is skipped
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(0, 0, 2560, 2560, 1'b0, 1'b1);
    // negative width and height
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(15000, 1280, -2560, -2560, 1'b0, 1'b1);
    // flat box lying along the line: parallel edges only
    add_query(0, 0, 25600, 0, 51200, 1'b0, 1'b0);
    add_box(5120, 0, 2560, 0, 1'b0, 1'b1);
    // answered queries, zero range and just out of range
    add_query(1000, 1000, 1000, 1000, 0, 1'b1, 1'b1);
    add_query(0, 0, 25600, 0, 25599, 1'b1, 1'b0);
    add_query(0, 0, 25600, 0, 100, 1'b0, 1'b0);
    add_box(12800, -1280, 2560, 2560, 1'b0, 1'b1);
    // extremes of the fields
    add_query(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 1'b0, 1'b0);
    add_box(MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD, 1'b0, 1'b1);
    add_query(MAX_COORD, MAX_COORD, 8388000, 8388000, MAX_COORD, 1'b0, 1'b0);
    add_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, 1'b0, 1'b0);
    add_box(8388300, 8388600, 100, -800, 1'b0, 1'b1);

    q_no = 0;
    while (item_q.size() < 22 + RANDOM_ITEMS) begin
      sc = ($urandom_range(0, 9) == 0) ? MAX_COORD : (1 << $urandom_range(6, 18));
      ox = span(sc);
      oy = span(sc);
      tx = span(sc);
      ty = span(sc);
      case ($urandom_range(0, 3))
        0: rng = $urandom_range(0, MAX_COORD);
        1: rng = $urandom_range(0, 3 * sc);
        default: rng = 3 * sc;
      endcase
      if (rng > MAX_COORD) rng = MAX_COORD;
      nobj = $urandom_range(0, 6);
      // now and then a query is abandoned for the next one
      if (nobj == 0 && $urandom_range(0, 3) == 0) begin
        add_query(ox, oy, tx, ty, rng, 1'b0, q_no % 50 == 10);
      end else begin
        add_query(ox, oy, tx, ty, rng, nobj == 0, q_no % 50 == 10);
      end
      for (int j = 0; j < nobj; j++) begin
        if ($urandom_range(0, 11) == 0) begin
          add_box($urandom(), $urandom(), $urandom(), $urandom(),
                  1'($urandom_range(0, 1)), j == nobj - 1);
        end else begin
          // box around a point on the sight line
          f = $urandom_range(0, 256);
          px = ox + ((longint'(tx) - ox) * f) / 256;
          py = oy + ((longint'(ty) - oy) * f) / 256;
          sz = sc / 8 + 1;
          w = $urandom_range(0, sz);
          h = $urandom_range(0, sz);
          bx = int'(px) - int'($urandom_range(0, w + w / 2));
          by = int'(py) - int'($urandom_range(0, h + h / 2));
          if ($urandom_range(0, 4) == 0) begin
            bx = bx + w;
            w = -w;
          end
          if ($urandom_range(0, 4) == 0) begin
            by = by + h;
            h = -h;
          end
          if ($urandom_range(0, 29) == 0) begin
            bx = ox;
            by = oy;
          end
          add_box(bx, by, w, h, $urandom_range(0, 9) == 0, j == nobj - 1);
        end
      end
      q_no++;
    end
    total_items = item_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_n != total_items || visible_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("line_of_sight_box_test_top_test: PASS");
    end else begin
      $display("line_of_sight_box_test_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- line_of_sight_box_test_top.f -----
rtl/losbt_pkg.sv
rtl/losbt_front.sv
rtl/losbt_mult.sv
rtl/losbt_eval.sv
rtl/line_of_sight_box_test_top.sv
tb/line_of_sight_box_test_top_test.sv
